/* hdl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on clk_i, masked while rst_ni is low
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on clk_i, also while reset is applied
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/qat_pkg.sv */
// types, constants and helpers for the quoted argument tokenizer
`default_nettype none
package qat_pkg;

  // scanner modes
  typedef enum logic [1:0] {
    ModeGap     = 2'd0,
    ModeComment = 2'd1,
    ModeBare    = 2'd2,
    ModeQuoted  = 2'd3
  } mode_e;

  // result kinds
  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindEot  = 2'd1,
    KindEnd  = 2'd2
  } kind_e;

  // special characters
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChNl     = 8'h0A;

  // result buffer sizing
  localparam int MaxRes   = 3;
  localparam int NumW     = $clog2(MaxRes + 1);
  localparam int ResDepth = 8;
  localparam int PtrW     = $clog2(ResDepth);
  localparam int CntW     = $clog2(ResDepth + 1);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  // group of results made by one text byte
  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [NumW-1:0]   num;
  } res_grp_t;

  // build one result; the data field is zero except for token bytes
  function automatic res_t mk_res(kind_e kind, logic [7:0] data, logic last);
    res_t r;
    r.kind = kind;
    r.data = (kind == KindByte) ? data : 8'h00;
    r.last = last;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/qat_decode.sv */
// scanner state and per-byte decode into up to three results
`default_nettype none
module qat_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  output qat_pkg::res_grp_t      grp_o
);

  qat_pkg::mode_e mode_q, mode_d;
  logic           quote_single_q, quote_single_d;
  logic           esc_q, esc_d;
  logic [7:0]     quote_ch;
  logic           is_sep;

  assign quote_ch = quote_single_q ? qat_pkg::ChSquote : qat_pkg::ChDquote;
  assign is_sep   = (byte_i inside {[8'd1 : qat_pkg::ChSpace]});

  // next state
  always_comb begin
    mode_d         = mode_q;
    quote_single_d = quote_single_q;
    esc_d          = esc_q;
    case (mode_q)
      qat_pkg::ModeGap: begin
        if (byte_i == qat_pkg::ChNul) begin
          mode_d = qat_pkg::ModeGap;
        end else if (is_sep) begin
          mode_d = qat_pkg::ModeGap;
        end else if (byte_i == qat_pkg::ChHash) begin
          mode_d = qat_pkg::ModeComment;
        end else if (byte_i inside {qat_pkg::ChDquote, qat_pkg::ChSquote}) begin
          mode_d         = qat_pkg::ModeQuoted;
          quote_single_d = (byte_i == qat_pkg::ChSquote);
          esc_d          = 1'b0;
        end else begin
          mode_d = qat_pkg::ModeBare;
        end
      end
      qat_pkg::ModeComment: begin
        if (byte_i == qat_pkg::ChNul || byte_i == qat_pkg::ChNl) begin
          mode_d = qat_pkg::ModeGap;
        end
      end
      qat_pkg::ModeBare: begin
        if (byte_i == qat_pkg::ChNul || is_sep) begin
          mode_d = qat_pkg::ModeGap;
        end
      end
      qat_pkg::ModeQuoted: begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (byte_i == qat_pkg::ChNul) begin
            mode_d         = qat_pkg::ModeGap;
            quote_single_d = 1'b0;
          end
        end else if (byte_i == qat_pkg::ChNul || byte_i == quote_ch) begin
          mode_d         = qat_pkg::ModeGap;
          quote_single_d = 1'b0;
        end else if (byte_i == qat_pkg::ChBslash) begin
          esc_d = 1'b1;
        end
      end
      default: begin
        mode_d = qat_pkg::ModeGap;
      end
    endcase
  end

  // results for this byte
  always_comb begin
    grp_o.res = '0;
    grp_o.num = '0;
    case (mode_q)
      qat_pkg::ModeGap: begin
        if (byte_i == qat_pkg::ChNul) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 1'b1);
          grp_o.num    = qat_pkg::NumW'(1);
        end else if (!is_sep && byte_i != qat_pkg::ChHash &&
                     byte_i != qat_pkg::ChDquote && byte_i != qat_pkg::ChSquote) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindByte, byte_i, 1'b1);
          grp_o.num    = qat_pkg::NumW'(1);
        end
      end
      qat_pkg::ModeComment: begin
        if (byte_i == qat_pkg::ChNul) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 1'b1);
          grp_o.num    = qat_pkg::NumW'(1);
        end
      end
      qat_pkg::ModeBare: begin
        if (byte_i == qat_pkg::ChNul) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindEot, 8'h00, 1'b0);
          grp_o.res[1] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 1'b1);
          grp_o.num    = qat_pkg::NumW'(2);
        end else if (is_sep) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindEot, 8'h00, 1'b1);
          grp_o.num    = qat_pkg::NumW'(1);
        end else begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindByte, byte_i, 1'b1);
          grp_o.num    = qat_pkg::NumW'(1);
        end
      end
      qat_pkg::ModeQuoted: begin
        if (esc_q) begin
          if (byte_i == qat_pkg::ChNul) begin
            // trailing backslash in an open quote
            grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindByte, qat_pkg::ChBslash, 1'b0);
            grp_o.res[1] = qat_pkg::mk_res(qat_pkg::KindEot, 8'h00, 1'b0);
            grp_o.res[2] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 1'b1);
            grp_o.num    = qat_pkg::NumW'(3);
          end else if (byte_i == quote_ch || byte_i == qat_pkg::ChBslash) begin
            grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindByte, byte_i, 1'b1);
            grp_o.num    = qat_pkg::NumW'(1);
          end else begin
            // backslash kept in front of an ordinary byte
            grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindByte, qat_pkg::ChBslash, 1'b0);
            grp_o.res[1] = qat_pkg::mk_res(qat_pkg::KindByte, byte_i, 1'b1);
            grp_o.num    = qat_pkg::NumW'(2);
          end
        end else if (byte_i == qat_pkg::ChNul) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindEot, 8'h00, 1'b0);
          grp_o.res[1] = qat_pkg::mk_res(qat_pkg::KindEnd, 8'h00, 1'b1);
          grp_o.num    = qat_pkg::NumW'(2);
        end else if (byte_i == quote_ch) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindEot, 8'h00, 1'b1);
          grp_o.num    = qat_pkg::NumW'(1);
        end else if (byte_i != qat_pkg::ChBslash) begin
          grp_o.res[0] = qat_pkg::mk_res(qat_pkg::KindByte, byte_i, 1'b1);
          grp_o.num    = qat_pkg::NumW'(1);
        end
      end
      default: begin
        grp_o.num = '0;
      end
    endcase
    if (!step_i) begin
      grp_o.num = '0;
    end
  end

  // scanner state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= qat_pkg::ModeGap;
      quote_single_q <= 1'b0;
      esc_q          <= 1'b0;
    end else if (step_i) begin
      mode_q         <= mode_d;
      quote_single_q <= quote_single_d;
      esc_q          <= esc_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/qat_res_fifo.sv */
// result buffer: takes up to three results a cycle, hands out one
`default_nettype none
module qat_res_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qat_pkg::res_grp_t grp_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output qat_pkg::res_t          head_o
);

  qat_pkg::res_t                  mem_q [qat_pkg::ResDepth];
  logic [qat_pkg::PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [qat_pkg::PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [qat_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                           pop;

  // room for a full group of results
  assign room_o  = (cnt_q <= qat_pkg::CntW'(qat_pkg::ResDepth - qat_pkg::MaxRes));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + qat_pkg::PtrW'(grp_i.num);
    rd_ptr_d = rd_ptr_q + qat_pkg::PtrW'(pop);
    cnt_d    = cnt_q + qat_pkg::CntW'(grp_i.num) - qat_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry writes, in result order
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < qat_pkg::MaxRes; i++) begin
      if (qat_pkg::NumW'(i) < grp_i.num) begin
        mem_q[wr_ptr_q + qat_pkg::PtrW'(i)] <= grp_i.res[i];
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/quoted_argument_tokenizer.sv */
// top level of the quoted argument tokenizer
// Usage:
//   Text bytes enter on the input channel (in_valid_i, in_ready_o,
//   text_byte_i); a zero byte ends a text and the next byte starts a new one.
//   Results leave on the output channel (out_valid_o, out_ready_i) as kind_o,
//   out_byte_o and last_of_run_o; last_of_run_o marks the final result of a
//   byte, and bytes with no result produce nothing on the output.
//   A byte passes from the input register through the decoder into the
//   result buffer; the input register hands a byte on every cycle the buffer
//   has room for three results, so the block takes one byte per cycle
//   while the output keeps up. Output is one result per cycle while the
//   receiver is ready, set by the single read port of the eight-entry buffer.
//   Reset returns the scanner to the between-tokens mode and empties the
//   input register and the result buffer.
//   When the receiver stalls, the buffer fills and in_ready_o drops once the
//   input register holds a byte that cannot be decoded; no result is lost.
`default_nettype none
module quoted_argument_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  logic              byte_v_q;
  logic [7:0]        byte_q;
  logic              room;
  logic              step;
  qat_pkg::res_grp_t grp;
  qat_pkg::res_t     head;

  // input register advances when the buffer can take a whole group
  assign step       = byte_v_q && room;
  assign in_ready_o = !byte_v_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_v_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= text_byte_i;
    end
  end

  // decode
  qat_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .grp_o  (grp)
  );

  // result buffer
  qat_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .grp_i   (grp),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign kind_o        = head.kind;
  assign out_byte_o    = head.data;
  assign last_of_run_o = head.last;

endmodule
`default_nettype wire

/* hdl/qat_checker.sv */
// port-level checker for the tokenizer, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module qat_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_run_o
);

  logic        kind_ok;
  logic        is_marker;
  logic        is_end;
  logic        stall;
  logic [10:0] out_word;

  // decoded views of the result ports
  assign kind_ok   = (kind_o == qat_pkg::KindByte) || (kind_o == qat_pkg::KindEot) ||
                     (kind_o == qat_pkg::KindEnd);
  assign is_marker = (kind_o != qat_pkg::KindByte);
  assign is_end    = (kind_o == qat_pkg::KindEnd);
  assign stall     = out_valid_o && !out_ready_i;
  assign out_word  = {kind_o, out_byte_o, last_of_run_o};

  // only the three defined kinds appear
  `ASSERT_CLKD(a_kind_known, out_valid_o |-> kind_ok, "undefined result kind")

  // markers carry a zero byte
  `ASSERT_CLKD(a_marker_zero, (out_valid_o && is_marker) |-> (out_byte_o == 8'h00), "marker byte")

  // end of text is always the final result of its byte
  `ASSERT_CLKD(a_end_last, (out_valid_o && is_end) |-> last_of_run_o, "end of text not last")

  // a stalled result holds
  `ASSERT_CLKD(a_out_hold, stall |=> (out_valid_o && $stable(out_word)), "stalled result changed")

  // no result shown while reset is applied
  `ASSERT_CLK_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result during reset")

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);
`default_nettype wire

/* dv/quoted_argument_tokenizer_tb.sv */
// testbench for the quoted argument tokenizer: directed and random text checked against a scanner model
`default_nettype none
module quoted_argument_tokenizer_tb;

  localparam int RandItems   = 86;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 30;
  localparam int DrainCycles = 20;
  localparam int NumDirected = 33;

  logic       clk_i       = 1'b0;
  logic       rst_ni;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  // text bytes waiting to be sent and results waiting to be seen
  logic [7:0]    text_q[$];
  qat_pkg::res_t token_q[$];

  // scanner state mirrored by the testbench
  qat_pkg::mode_e scan_mode    = qat_pkg::ModeGap;
  logic           quote_single = 1'b0;
  logic           esc_wait     = 1'b0;

  int err_n      = 0;
  int cyc_n      = 0;
  int gap_left   = 0;
  int burst_left = 1;
  int taken_n    = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int rcv_cyc    = 0;

  logic [7:0] directed_text [0:NumDirected-1];

  quoted_argument_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    err_n++;
  endtask

  function automatic qat_pkg::res_t token_res(qat_pkg::kind_e kind, logic [7:0] data);
    qat_pkg::res_t r;
    r.kind = kind;
    r.data = (kind == qat_pkg::KindByte) ? data : 8'h00;
    r.last = 1'b0;
    return r;
  endfunction

  // advance the scanner by one text byte and queue the results it causes
  task automatic scan_byte(input logic [7:0] b);
    qat_pkg::res_t step_q[$];
    logic [7:0]    close_ch;
    bit            text_end;
    close_ch = quote_single ? qat_pkg::ChSquote : qat_pkg::ChDquote;
    text_end = 1'b0;
    case (scan_mode)
      qat_pkg::ModeGap: begin
        if (b == qat_pkg::ChNul) begin
          text_end = 1'b1;
        end else if (b <= qat_pkg::ChSpace) begin
          // separator
        end else if (b == qat_pkg::ChHash) begin
          scan_mode = qat_pkg::ModeComment;
        end else if (b == qat_pkg::ChDquote || b == qat_pkg::ChSquote) begin
          scan_mode    = qat_pkg::ModeQuoted;
          quote_single = (b == qat_pkg::ChSquote);
          esc_wait     = 1'b0;
        end else begin
          scan_mode = qat_pkg::ModeBare;
          step_q.push_back(token_res(qat_pkg::KindByte, b));
        end
      end
      qat_pkg::ModeComment: begin
        if (b == qat_pkg::ChNul) text_end = 1'b1;
        else if (b == qat_pkg::ChNl) scan_mode = qat_pkg::ModeGap;
      end
      qat_pkg::ModeBare: begin
        if (b == qat_pkg::ChNul) begin
          step_q.push_back(token_res(qat_pkg::KindEot, 8'h00));
          text_end = 1'b1;
        end else if (b <= qat_pkg::ChSpace) begin
          step_q.push_back(token_res(qat_pkg::KindEot, 8'h00));
          scan_mode = qat_pkg::ModeGap;
        end else begin
          step_q.push_back(token_res(qat_pkg::KindByte, b));
        end
      end
      default: begin
        if (esc_wait) begin
          esc_wait = 1'b0;
          if (b == qat_pkg::ChNul) begin
            // trailing backslash is kept
            step_q.push_back(token_res(qat_pkg::KindByte, qat_pkg::ChBslash));
            step_q.push_back(token_res(qat_pkg::KindEot, 8'h00));
            text_end = 1'b1;
          end else if (b == close_ch || b == qat_pkg::ChBslash) begin
            step_q.push_back(token_res(qat_pkg::KindByte, b));
          end else begin
            step_q.push_back(token_res(qat_pkg::KindByte, qat_pkg::ChBslash));
            step_q.push_back(token_res(qat_pkg::KindByte, b));
          end
        end else if (b == qat_pkg::ChNul) begin
          step_q.push_back(token_res(qat_pkg::KindEot, 8'h00));
          text_end = 1'b1;
        end else if (b == close_ch) begin
          step_q.push_back(token_res(qat_pkg::KindEot, 8'h00));
          scan_mode    = qat_pkg::ModeGap;
          quote_single = 1'b0;
        end else if (b == qat_pkg::ChBslash) begin
          esc_wait = 1'b1;
        end else begin
          step_q.push_back(token_res(qat_pkg::KindByte, b));
        end
      end
    endcase
    // end of text clears the scanner
    if (text_end) begin
      step_q.push_back(token_res(qat_pkg::KindEnd, 8'h00));
      scan_mode    = qat_pkg::ModeGap;
      quote_single = 1'b0;
      esc_wait     = 1'b0;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endtask

  // sender: bursts of items with random gaps, prediction at each accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) scan_byte(text_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_valid_i  <= 1'b1;
          text_byte_i <= text_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) taken_n++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && taken_n == HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        case (rcv_cyc[7:6])
          2'd0:    out_ready_i <= 1'b1;
          2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
          2'd2:    out_ready_i <= (rcv_cyc % 3 == 0);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
      rcv_cyc++;
    end
  end

  // monitor: compare each result with the oldest expected one
  always @(posedge clk_i) begin
    qat_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (token_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d byte=%02h last=%0b",
                                  kind_o, out_byte_o, last_of_run_o));
      end else begin
        want = token_q.pop_front();
        if (kind_o !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", kind_o, want.kind));
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("byte %02h, expected %02h", out_byte_o, want.data));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", last_of_run_o, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc_n++;
    if (cyc_n > CycleLimit) begin
      $display("quoted_argument_tokenizer_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int         len;
    int         pick;
    logic [7:0] qch;

    rst_ni <= 1'b0;
    // directed text: bare token with quote and hash inside, comment, escapes,
    // empty quotes, quote closing a token directly, trailing backslash,
    // comment ended by zero, unterminated quote, zero between tokens
    directed_text = '{8'h01, 8'h61, qat_pkg::ChHash, qat_pkg::ChDquote, 8'hFF,
                      qat_pkg::ChSpace,
                      qat_pkg::ChHash, 8'h78, qat_pkg::ChNl,
                      qat_pkg::ChDquote, qat_pkg::ChBslash, qat_pkg::ChDquote,
                      qat_pkg::ChBslash, qat_pkg::ChBslash,
                      qat_pkg::ChBslash, 8'h71, qat_pkg::ChDquote,
                      qat_pkg::ChSquote, qat_pkg::ChSquote,
                      qat_pkg::ChSquote, 8'h6B, qat_pkg::ChSquote, 8'h6D, qat_pkg::ChNul,
                      qat_pkg::ChSquote, qat_pkg::ChBslash, qat_pkg::ChNul,
                      qat_pkg::ChHash, qat_pkg::ChNul,
                      qat_pkg::ChDquote, 8'h80, qat_pkg::ChNul,
                      qat_pkg::ChNul};
    foreach (directed_text[i]) text_q.push_back(directed_text[i]);

    // random text built mostly from well-formed tokens
    while (text_q.size() < NumDirected + RandItems) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: begin
          len = $urandom_range(1, 4);
          repeat (len) text_q.push_back(8'($urandom_range(8'h21, 8'hFF)));
          text_q.push_back(8'($urandom_range(8'h01, 8'h20)));
        end
        3, 4, 5: begin
          qch = $urandom_range(0, 1) ? qat_pkg::ChSquote : qat_pkg::ChDquote;
          text_q.push_back(qch);
          len = $urandom_range(0, 5);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0: begin
                text_q.push_back(qat_pkg::ChBslash);
                case ($urandom_range(0, 2))
                  0:       text_q.push_back(qch);
                  1:       text_q.push_back(qat_pkg::ChBslash);
                  default: text_q.push_back(8'($urandom_range(8'h01, 8'hFF)));
                endcase
              end
              1: text_q.push_back((qch == qat_pkg::ChSquote) ? qat_pkg::ChDquote
                                                             : qat_pkg::ChSquote);
              default: text_q.push_back(8'($urandom_range(8'h01, 8'hFF)));
            endcase
          end
          if ($urandom_range(0, 4) != 0) text_q.push_back(qch);
        end
        6: begin
          text_q.push_back(qat_pkg::ChHash);
          repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(8'h01, 8'hFF)));
          text_q.push_back(qat_pkg::ChNl);
        end
        7: begin
          text_q.push_back(qat_pkg::ChNul);
        end
        8: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(8'h01, 8'h20)));
        default: begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    text_q.push_back(qat_pkg::ChNul);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent and every expected result seen
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid_i || token_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (token_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", token_q.size()));

    if (err_n == 0) begin
      $display("quoted_argument_tokenizer_tb: PASS");
    end else begin
      $display("quoted_argument_tokenizer_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
